FILE: design/dcs_pkg.sv
`default_nettype none
package dcs_pkg;

	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_QUERY_LEFT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_QUERY_TOP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_QUERY_RIGHT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_QUERY_BOTTOM = 2'd3;

	localparam int unsigned Q_DEPTH = 4;
	localparam int unsigned Q_PTR_W = 2;
	localparam int unsigned Q_CNT_W = 3;

	typedef struct packed {
		logic [3:0] output_index;
		logic output_active;
		logic has_mode;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic [14:0] mode_width;
		logic [14:0] mode_height;
		logic quarter_turn;
		logic is_primary;
		logic last_output;
	} in_word_t;

	typedef struct packed {
		logic found;
		logic [3:0] best_output;
		logic [31:0] best_area;
	} out_word_t;

	// classified word passed from front to back
	typedef struct packed {
		logic cand;
		logic primary;
		logic last;
		logic [3:0] idx;
		logic [15:0] sx;
		logic [15:0] sy;
	} cls_t;

	function automatic logic [15:0] span(input logic signed [15:0] a1,
			input logic signed [15:0] a2, input logic signed [15:0] b1,
			input logic signed [15:0] b2);
		logic signed [15:0] lo;
		logic signed [15:0] hi;
		logic [16:0] d;
		lo = (a1 > b1) ? a1 : b1;
		hi = (a2 < b2) ? a2 : b2;
		d = {hi[15], hi} - {lo[15], lo};
		if (lo >= hi) begin
			span = 16'd0;
		end else begin
			span = d[15:0];
		end
	endfunction

endpackage
`default_nettype wire

FILE: design/dcs_front.sv
`default_nettype none
module dcs_front #(
	parameter int unsigned MAX_OUTPUTS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_wen,
	input wire logic [dcs_pkg::CFG_IDX_W-1:0] cfg_idx,
	input wire logic [dcs_pkg::CFG_DATA_W-1:0] cfg_data,
	input wire logic item_valid,
	output logic item_stall,
	input wire dcs_pkg::in_word_t item,
	output logic push,
	output dcs_pkg::cls_t push_word,
	input wire logic q_full
);

	logic signed [15:0] qleft_q, qtop_q, qright_q, qbottom_q;
	logic s1_vld_q;
	dcs_pkg::cls_t s1_word_s1;
	logic need;
	logic [14:0] w, h;
	logic signed [15:0] x1, y1, x2, y2;
	logic [15:0] sx, sy;
	logic cand;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qleft_q <= '0;
			qtop_q <= '0;
			qright_q <= '0;
			qbottom_q <= '0;
		end else if (cfg_wen) begin
			case (cfg_idx)
				dcs_pkg::CFG_QUERY_LEFT: qleft_q <= $signed(cfg_data);
				dcs_pkg::CFG_QUERY_TOP: qtop_q <= $signed(cfg_data);
				dcs_pkg::CFG_QUERY_RIGHT: qright_q <= $signed(cfg_data);
				dcs_pkg::CFG_QUERY_BOTTOM: qbottom_q <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	always_comb begin
		w = item.quarter_turn ? item.mode_height : item.mode_width;
		h = item.quarter_turn ? item.mode_width : item.mode_height;
		if (item.has_mode) begin
			x1 = $signed(item.pos_x);
			y1 = $signed(item.pos_y);
			x2 = $signed(item.pos_x + {1'b0, w});
			y2 = $signed(item.pos_y + {1'b0, h});
		end else begin
			x1 = '0;
			y1 = '0;
			x2 = '0;
			y2 = '0;
		end
		sx = dcs_pkg::span(x1, x2, qleft_q, qright_q);
		sy = dcs_pkg::span(y1, y2, qtop_q, qbottom_q);
		cand = item.output_active && (32'(item.output_index) < MAX_OUTPUTS);
	end

	// non-candidate (inactive or out-of-range index) non-final words are dropped here
	assign need = s1_word_s1.cand || s1_word_s1.last;
	assign item_stall = s1_vld_q && need && q_full;
	assign push = s1_vld_q && need && !q_full;
	assign push_word = s1_word_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q <= 1'b0;
		end else if (!item_stall) begin
			s1_vld_q <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall) begin
			s1_word_s1.cand <= cand;
			s1_word_s1.primary <= item.is_primary;
			s1_word_s1.last <= item.last_output;
			s1_word_s1.idx <= item.output_index;
			s1_word_s1.sx <= sx;
			s1_word_s1.sy <= sy;
		end
	end

endmodule
`default_nettype wire

FILE: design/dcs_queue.sv
`default_nettype none
module dcs_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire dcs_pkg::cls_t push_word,
	output logic full,
	input wire logic pop,
	output logic empty,
	output dcs_pkg::cls_t head
);

	dcs_pkg::cls_t mem [dcs_pkg::Q_DEPTH];
	logic [dcs_pkg::Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [dcs_pkg::Q_CNT_W-1:0] cnt_q;
	logic do_push, do_pop;

	assign full = (cnt_q == dcs_pkg::Q_CNT_W'(dcs_pkg::Q_DEPTH));
	assign empty = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign head = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_word;
		end
	end

endmodule
`default_nettype wire

FILE: design/dcs_back.sv
`default_nettype none
module dcs_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic q_empty,
	input wire dcs_pkg::cls_t head,
	output logic pop,
	output logic result_valid,
	input wire logic result_stall,
	output dcs_pkg::out_word_t result
);

	logic s2_vld_q;
	logic s2_cand_s2, s2_primary_s2, s2_last_s2;
	logic [3:0] s2_idx_s2;
	logic [31:0] s2_area_s2;
	logic best_vld_q;
	logic [3:0] best_id_q;
	logic [31:0] best_area_q;
	logic out_vld_q;
	dcs_pkg::out_word_t out_q;
	logic fire, upd;
	logic n_vld;
	logic [3:0] n_id;
	logic [31:0] n_area;

	assign fire = s2_vld_q && !(s2_last_s2 && out_vld_q && result_stall);
	assign pop = !q_empty && (!s2_vld_q || fire);
	assign result_valid = out_vld_q;
	assign result = out_q;

	always_comb begin
		upd = s2_cand_s2 && ((s2_area_s2 > best_area_q) ||
			((s2_area_s2 == best_area_q) && s2_primary_s2));
		n_vld = upd ? 1'b1 : best_vld_q;
		n_id = upd ? s2_idx_s2 : best_id_q;
		n_area = upd ? s2_area_s2 : best_area_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_vld_q <= 1'b0;
			best_vld_q <= 1'b0;
			best_id_q <= '0;
			best_area_q <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (!s2_vld_q || fire) begin
				s2_vld_q <= !q_empty;
			end
			if (fire) begin
				if (s2_last_s2) begin
					best_vld_q <= 1'b0;
					best_id_q <= '0;
					best_area_q <= '0;
				end else begin
					best_vld_q <= n_vld;
					best_id_q <= n_id;
					best_area_q <= n_area;
				end
			end
			if (fire && s2_last_s2) begin
				out_vld_q <= 1'b1;
			end else if (!result_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			s2_cand_s2 <= head.cand;
			s2_primary_s2 <= head.primary;
			s2_last_s2 <= head.last;
			s2_idx_s2 <= head.idx;
			s2_area_s2 <= 32'(head.sx) * 32'(head.sy);
		end
		if (fire && s2_last_s2) begin
			out_q.found <= n_vld;
			out_q.best_output <= n_vld ? n_id : 4'd0;
			out_q.best_area <= n_vld ? n_area : 32'd0;
		end
	end

endmodule
`default_nettype wire

FILE: design/display_coverage_select.sv
// A result is registered once its last word has crossed the front register, queue and back stage; stalls delay it.
// Throughput: one descriptor word per cycle; the front register, a 4-entry queue and
// the multiply/compare stage each advance every cycle while nothing downstream stalls.
// Reset: arst_n clears the query registers, the running best and all valid flags;
// the block takes words in the first cycle after reset.
`default_nettype none
module display_coverage_select #(
	parameter int unsigned MAX_OUTPUTS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_wen,
	input wire logic [dcs_pkg::CFG_IDX_W-1:0] cfg_idx,
	input wire logic [dcs_pkg::CFG_DATA_W-1:0] cfg_data,
	input wire logic item_valid,
	output logic item_stall,
	input wire dcs_pkg::in_word_t item,
	output logic result_valid,
	input wire logic result_stall,
	output dcs_pkg::out_word_t result
);

	logic push, q_full, q_empty, pop;
	dcs_pkg::cls_t push_word, head;

	dcs_front #(
		.MAX_OUTPUTS(MAX_OUTPUTS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.push(push),
		.push_word(push_word),
		.q_full(q_full)
	);

	dcs_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_word(push_word),
		.full(q_full),
		.pop(pop),
		.empty(q_empty),
		.head(head)
	);

	dcs_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.head(head),
		.pop(pop),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

endmodule
`default_nettype wire
